// File: hw/rtl/t9kps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t9kps_pkg
// Shared types, constants and helpers of the T9 key prefix search unit.
// ----------------------------------------------------------------------------
package t9kps_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned MatchLimit = 8;
  localparam int unsigned MaxDigits  = 16;

  localparam int unsigned IdxW   = $clog2(TableDepth);
  localparam int unsigned CntW   = $clog2(TableDepth + 1);
  localparam int unsigned GotW   = $clog2(MatchLimit + 1);
  localparam int unsigned KeyW   = 4 * MaxDigits;
  localparam int unsigned DCntW  = $clog2(MaxDigits + 1);
  localparam int unsigned Regions = 10;

  typedef enum logic [1:0] {
    KIND_LOAD         = 2'd0,
    KIND_LOOKUP       = 2'd1,
    KIND_RESET_SEARCH = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_KEY = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SINGLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_PRE_RD,
    ST_PRE_CMP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [IdxW-1:0] entry_index;
    logic            exact;
    logic            found;
    status_e         status;
    logic            last;
  } result_t;

  // one nibble of ones for every used digit, first digit at the top
  function automatic logic [KeyW-1:0] lead_mask(input logic [DCntW-1:0] n);
    logic [KeyW-1:0] m;
    m = '0;
    for (int p = 0; p < MaxDigits; p++) begin
      if (p < n) begin
        m[KeyW-1-4*p -: 4] = 4'hF;
      end
    end
    return m;
  endfunction

  // every used digit lies in 1..9
  function automatic logic digits_ok(input logic [KeyW-1:0] key,
                                     input logic [DCntW-1:0] n);
    logic ok;
    logic [3:0] d;
    ok = 1'b1;
    for (int p = 0; p < MaxDigits; p++) begin
      d = key[KeyW-1-4*p -: 4];
      if (p < n && (d < 4'd1 || d > 4'd9)) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// File: hw/rtl/t9kps_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t9kps_req_if
// Request channel: operation kind, packed key digits and digit count.
// ----------------------------------------------------------------------------
interface t9kps_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [t9kps_pkg::KeyW-1:0]     key_digits;
  logic [t9kps_pkg::DCntW-1:0]    digit_count;

  modport source (output valid, kind, key_digits, digit_count, input ready);
  modport sink (input valid, kind, key_digits, digit_count, output ready);
endinterface

// File: hw/rtl/t9kps_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t9kps_rsp_if
// Result channel: entry index, match flags, status and last marker.
// ----------------------------------------------------------------------------
interface t9kps_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [t9kps_pkg::IdxW-1:0] entry_index;
  logic                       exact;
  logic                       found;
  logic [1:0]                 status;
  logic                       last;

  modport source (output valid, entry_index, exact, found, status, last, input ready);
  modport sink (input valid, entry_index, exact, found, status, last, output ready);
endinterface

// File: hw/rtl/t9kps_key_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t9kps_key_store
// Key code memory, one write and one registered read port; entries at or
// past the fill count read as zero.
// ----------------------------------------------------------------------------
module t9kps_key_store (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [t9kps_pkg::IdxW-1:0] wr_addr_i,
  input  logic [t9kps_pkg::KeyW-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [t9kps_pkg::IdxW-1:0] rd_addr_i,
  input  logic [t9kps_pkg::CntW-1:0] fill_i,
  output logic [t9kps_pkg::KeyW-1:0] rd_data_o
);
  import t9kps_pkg::*;

  logic [KeyW-1:0] mem [TableDepth];
  logic [KeyW-1:0] rdata_q;
  logic            rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q  <= mem[rd_addr_i];
      rvalid_q <= {1'b0, rd_addr_i} < fill_i;
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

// File: hw/rtl/t9_key_prefix_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t9_key_prefix_search_unit
// Table of T9 key codes with load, lookup and cursor reset requests.
//
// Requests arrive on req (kind, key_digits, digit_count); results leave on
// rsp, one or more per request, the final one marked by last. One request is
// handled at a time: req.ready is high only while the unit is idle.
// A load, a cursor reset or a rejected key gives one result, passing from
// the decide state through the single state. A lookup reads the key memory
// once per entry visited, in a read state then a compare state, as the key
// memory has a single read port. Matches are emitted as they are found, one
// behind, so the last result follows the final compare.
// Reset empties the table (fill count to zero, so no clearing pass), clears
// the region bounds, the search cursor and the previous length.
// A stalled receiver holds the result register; the search waits in place
// until the register drains and loses nothing.
// ----------------------------------------------------------------------------
module t9_key_prefix_search_unit (
  input logic         clk_i,
  input logic         rst_ni,
  t9kps_req_if.sink   req,
  t9kps_rsp_if.source rsp
);
  import t9kps_pkg::*;

  state_e state_q, state_d;

  logic [1:0]       kind_q;
  logic [KeyW-1:0]  key_q;
  logic [DCntW-1:0] cnt_q;

  logic [CntW-1:0]  total_q, total_d;
  logic [IdxW-1:0]  reg_first_q [Regions];
  logic [IdxW-1:0]  reg_last_q [Regions];
  logic [Regions-1:0] reg_seen_q;
  logic [CntW-1:0]  cursor_q, cursor_d;
  logic [DCntW-1:0] prev_len_q, prev_len_d;

  logic [IdxW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [CntW-1:0]  i_q, i_d, steps_q, steps_d, span_q, span_d, m_q, m_d;
  logic [GotW-1:0]  got_q, got_d;
  logic [IdxW-1:0]  same_q, same_d;
  logic             same_v_q, same_v_d;
  logic [CntW-1:0]  pre_q, pre_d;

  result_t          pend_q, pend_d;
  logic             pend_v_q, pend_v_d;
  result_t          single_q, single_d;
  result_t          out_q, out_d;
  logic             out_v_q, out_v_d;

  logic             wr_en, rd_en, reg_upd;
  logic [IdxW-1:0]  rd_addr;
  logic [KeyW-1:0]  rd_data;
  logic [KeyW-1:0]  mask, code;
  logic [3:0]       dig;
  logic             slot_free;
  logic [CntW-1:0]  cur_n;

  assign mask      = lead_mask(cnt_q);
  assign code      = key_q & mask;
  assign dig       = key_q[KeyW-1 -: 4];
  assign slot_free = !out_v_q || rsp.ready;

  t9kps_key_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (total_q[IdxW-1:0]),
    .wr_data_i (code),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .fill_i    (total_q),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d    = state_q;
    total_d    = total_q;
    cursor_d   = cursor_q;
    prev_len_d = prev_len_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    i_d        = i_q;
    steps_d    = steps_q;
    span_d     = span_q;
    m_d        = m_q;
    got_d      = got_q;
    same_d     = same_q;
    same_v_d   = same_v_q;
    pre_d      = pre_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    single_d   = single_q;
    out_d      = out_q;
    out_v_d    = out_v_q && !rsp.ready;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    reg_upd    = 1'b0;
    rd_addr    = i_q[IdxW-1:0];
    cur_n      = '0;

    case (state_q)
      ST_IDLE: begin
        if (req.valid) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        single_d = '{entry_index: '0, exact: 1'b0, found: 1'b0,
                     status: STATUS_OK, last: 1'b1};
        state_d  = ST_SINGLE;
        case (kind_q)
          KIND_LOAD: begin
            if (cnt_q < DCntW'(1) || cnt_q > DCntW'(MaxDigits) ||
                dig < 4'd1 || dig > 4'd9) begin
              single_d.status = STATUS_BAD_KEY;
            end else if (total_q >= CntW'(TableDepth)) begin
              single_d.status = STATUS_FULL;
            end else begin
              wr_en    = 1'b1;
              reg_upd  = 1'b1;
              total_d  = total_q + CntW'(1);
              single_d.entry_index = total_q[IdxW-1:0];
            end
          end
          KIND_LOOKUP: begin
            if (cnt_q < DCntW'(1) || cnt_q > DCntW'(MaxDigits) ||
                !digits_ok(key_q, cnt_q)) begin
              single_d.status = STATUS_BAD_KEY;
            end else begin
              lo_d  = reg_first_q[dig];
              hi_d  = reg_last_q[dig];
              cur_n = (cursor_q >= total_q) ? '0 : cursor_q;
              if (prev_len_q > cnt_q || cnt_q == DCntW'(1) ||
                  cur_n > {1'b0, hi_d} || cur_n < {1'b0, lo_d}) begin
                cur_n = {1'b0, lo_d};
              end
              cursor_d = cur_n;
              i_d      = cur_n;
              steps_d  = '0;
              span_d   = (hi_d >= lo_d) ? ({1'b0, hi_d} - {1'b0, lo_d} + CntW'(1))
                                        : CntW'(1);
              got_d    = '0;
              same_v_d = 1'b0;
              pend_v_d = 1'b0;
              state_d  = ST_SCAN_RD;
            end
          end
          KIND_RESET_SEARCH: begin
            cursor_d   = '0;
            prev_len_d = '0;
          end
          default: begin
          end
        endcase
      end
      ST_SINGLE: begin
        if (slot_free) begin
          out_d   = single_q;
          out_v_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        if (steps_q == span_q) begin
          state_d = ST_FINISH;
        end else begin
          if (i_q > {1'b0, hi_q}) begin
            i_d = {1'b0, lo_q};
          end
          rd_addr = i_d[IdxW-1:0];
          rd_en   = 1'b1;
          state_d = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (rd_data == code) begin
          if (!pend_v_q || slot_free) begin
            if (pend_v_q) begin
              out_d   = pend_q;
              out_v_d = 1'b1;
            end
            pend_d   = '{entry_index: i_q[IdxW-1:0], exact: 1'b1, found: 1'b1,
                         status: STATUS_OK, last: 1'b0};
            pend_v_d = 1'b1;
            got_d    = got_q + GotW'(1);
            same_d   = i_q[IdxW-1:0];
            same_v_d = 1'b1;
            if (got_d == GotW'(MatchLimit)) begin
              state_d = ST_FINISH;
            end else begin
              i_d     = i_q + CntW'(1);
              steps_d = steps_q + CntW'(1);
              state_d = ST_SCAN_RD;
            end
          end
        end else if (got_q != '0) begin
          pre_d   = {1'b0, same_q} + CntW'(1);
          m_d     = pre_d;
          state_d = ST_PRE_RD;
        end else if ((rd_data & mask) == code) begin
          pre_d   = i_q;
          m_d     = i_q;
          state_d = ST_PRE_RD;
        end else begin
          i_d     = i_q + CntW'(1);
          steps_d = steps_q + CntW'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_PRE_RD: begin
        if (got_q < GotW'(MatchLimit) && m_q < total_q) begin
          rd_addr = m_q[IdxW-1:0];
          rd_en   = 1'b1;
          state_d = ST_PRE_CMP;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_PRE_CMP: begin
        if ((rd_data & mask) != code) begin
          state_d = ST_FINISH;
        end else if (!pend_v_q || slot_free) begin
          if (pend_v_q) begin
            out_d   = pend_q;
            out_v_d = 1'b1;
          end
          pend_d   = '{entry_index: m_q[IdxW-1:0], exact: rd_data == code,
                       found: 1'b1, status: STATUS_OK, last: 1'b0};
          pend_v_d = 1'b1;
          got_d    = got_q + GotW'(1);
          m_d      = m_q + CntW'(1);
          state_d  = ST_PRE_RD;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_v_d = 1'b1;
          state_d = ST_IDLE;
          if (got_q == '0) begin
            out_d = '{entry_index: '0, exact: 1'b0, found: 1'b0,
                      status: STATUS_OK, last: 1'b1};
          end else begin
            out_d      = pend_q;
            out_d.last = 1'b1;
            pend_v_d   = 1'b0;
            cursor_d   = same_v_q ? ({1'b0, same_q} + CntW'(1)) : (pre_q + CntW'(1));
            prev_len_d = cnt_q;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign req.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      total_q    <= '0;
      cursor_q   <= '0;
      prev_len_q <= '0;
      reg_seen_q <= '0;
      out_v_q    <= 1'b0;
      pend_v_q   <= 1'b0;
      got_q      <= '0;
      same_v_q   <= 1'b0;
      for (int r = 0; r < Regions; r++) begin
        reg_first_q[r] <= '0;
        reg_last_q[r]  <= '0;
      end
    end else begin
      state_q    <= state_d;
      total_q    <= total_d;
      cursor_q   <= cursor_d;
      prev_len_q <= prev_len_d;
      out_v_q    <= out_v_d;
      pend_v_q   <= pend_v_d;
      got_q      <= got_d;
      same_v_q   <= same_v_d;
      if (reg_upd) begin
        if (!reg_seen_q[dig]) begin
          reg_seen_q[dig]  <= 1'b1;
          reg_first_q[dig] <= total_q[IdxW-1:0];
        end
        reg_last_q[dig] <= total_q[IdxW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      kind_q <= req.kind;
      key_q  <= req.key_digits;
      cnt_q  <= req.digit_count;
    end
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    i_q      <= i_d;
    steps_q  <= steps_d;
    span_q   <= span_d;
    m_q      <= m_d;
    same_q   <= same_d;
    pre_q    <= pre_d;
    pend_q   <= pend_d;
    single_q <= single_d;
    out_q    <= out_d;
  end

  assign rsp.valid       = out_v_q;
  assign rsp.entry_index = out_q.entry_index;
  assign rsp.exact       = out_q.exact;
  assign rsp.found       = out_q.found;
  assign rsp.status      = out_q.status;
  assign rsp.last        = out_q.last;

  a_got_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    got_q <= GotW'(MatchLimit))
    else $error("match count beyond limit");

  a_total_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntW'(TableDepth))
    else $error("fill count beyond table depth");

  a_found_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.found |-> out_q.status == STATUS_OK)
    else $error("match carries error status");

  a_exact_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_q.found |-> !out_q.exact && out_q.last)
    else $error("no-match result malformed");

endmodule
